/* hw/rtl/tpp_pkg.sv */
// Shared constants for the perspective point transform.
// Used by the top level and the divider lane; depends on nothing else.
package tpp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 8;
  localparam int N_REGS        = 8;
  localparam int REG_SEL_W     = $clog2(N_REGS);
  // A column sum has a magnitude below 2**64 for any fraction width in range.
  localparam int SUM_W         = 66;
  localparam int MAG_W         = SUM_W - 1;
  localparam int QUO_W         = COORD_W + 1;
  // One overflow check followed by one step per quotient bit.
  localparam int DIV_STEPS     = QUO_W + 1;

  localparam logic [REG_SEL_W-1:0] REG_COL0_ROWS01 = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_COL0_ROWS23 = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_COL1_ROWS01 = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_COL1_ROWS23 = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_COL2_ROWS01 = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_COL2_ROWS23 = 3'd5;
  localparam logic [REG_SEL_W-1:0] REG_COL3_ROWS01 = 3'd6;
  localparam logic [REG_SEL_W-1:0] REG_COL3_ROWS23 = 3'd7;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

endpackage

/* hw/rtl/tpp_div_lane.sv */
// One lane of the pipelined restoring divider: one quotient bit per stage.
// Depends on tpp_pkg; stage enables come from the top level.
module tpp_div_lane #(
  parameter int FRAC_BITS = tpp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [tpp_pkg::DIV_STEPS-1:0]      en,
  input  logic [tpp_pkg::MAG_W-1:0]          num_mag,
  input  logic [tpp_pkg::MAG_W-1:0]          den,
  input  logic                               neg_in,
  output logic [tpp_pkg::QUO_W-1:0]          quo,
  output logic                               ovf,
  output logic                               neg
);

  localparam int STEPS = tpp_pkg::DIV_STEPS;
  localparam int RW    = tpp_pkg::MAG_W + STEPS;

  logic [RW-1:0]               rem_s [STEPS];
  logic [tpp_pkg::MAG_W-1:0]   den_s [STEPS];
  logic [tpp_pkg::QUO_W-1:0]   quo_s [STEPS];
  logic                        ovf_s [STEPS];
  logic                        neg_s [STEPS];

  // The first stage only checks whether the quotient reaches 2**33.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_s[0] <= RW'(num_mag) << FRAC_BITS;
      den_s[0] <= den;
      quo_s[0] <= '0;
      ovf_s[0] <= ((RW'(num_mag) << FRAC_BITS) >= (RW'(den) << (STEPS - 1)));
      neg_s[0] <= neg_in;
    end
  end

  for (genvar k = 1; k < STEPS; k++) begin : g_step
    logic [RW-1:0] dsh;
    logic          fits;
    assign dsh  = RW'(den_s[k-1]) << (STEPS - 1 - k);
    assign fits = rem_s[k-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_s[k] <= fits ? rem_s[k-1] - dsh : rem_s[k-1];
        den_s[k] <= den_s[k-1];
        quo_s[k] <= quo_s[k-1] | (fits ? (tpp_pkg::QUO_W'(1) << (STEPS - 1 - k)) : '0);
        ovf_s[k] <= ovf_s[k-1];
        neg_s[k] <= neg_s[k-1];
      end
    end
  end

  assign quo = quo_s[STEPS-1];
  assign ovf = ovf_s[STEPS-1];
  assign neg = neg_s[STEPS-1];

endmodule

/* hw/rtl/transform_point_perspective_unit.sv */
// Top level of the perspective point transform.
// Depends on tpp_pkg and tpp_div_lane.

// The block multiplies the point (x, y, z, 1) by the configured 4x4 matrix and divides
// the x, y and z sums by the w sum, giving signed fixed-point results truncated toward
// zero and saturated to 32 bits. It takes one word per cycle while in_stall is low, and each
// word passes in turn through one stage of multipliers, one of column adders, one of sign
// handling and 34 stages of the restoring divider, which sets the depth, then the output
// register. Stages advance independently, so gaps close up while the output is stalled.
module transform_point_perspective_unit #(
  parameter int FRAC_BITS = tpp_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [tpp_pkg::COORD_W-1:0]      in_x,
  input  logic signed [tpp_pkg::COORD_W-1:0]      in_y,
  input  logic signed [tpp_pkg::COORD_W-1:0]      in_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tpp_pkg::COORD_W-1:0]      out_x,
  output logic signed [tpp_pkg::COORD_W-1:0]      out_y,
  output logic signed [tpp_pkg::COORD_W-1:0]      out_z,
  output logic                                    div_by_zero,
  output logic                                    saturated,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [tpp_pkg::CFG_W-1:0]               cfg_data
);

  localparam int CW    = tpp_pkg::COORD_W;
  localparam int SW    = tpp_pkg::SUM_W;
  localparam int MW    = tpp_pkg::MAG_W;
  localparam int QW    = tpp_pkg::QUO_W;
  localparam int DS    = tpp_pkg::DIV_STEPS;
  localparam int DIV0  = 3;
  localparam int OUTS  = DIV0 + DS;
  localparam int S     = OUTS + 1;
  localparam logic [tpp_pkg::CFG_W-1:0] ONE_LO = 64'd1 << FRAC_BITS;
  localparam logic [tpp_pkg::CFG_W-1:0] ONE_HI = ONE_LO << CW;

  // Configuration registers.
  logic [tpp_pkg::CFG_W-1:0] regs [tpp_pkg::N_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tpp_pkg::N_REGS; i++) regs[i] <= '0;
      regs[tpp_pkg::REG_COL0_ROWS01] <= ONE_LO;
      regs[tpp_pkg::REG_COL1_ROWS01] <= ONE_HI;
      regs[tpp_pkg::REG_COL2_ROWS23] <= ONE_LO;
      regs[tpp_pkg::REG_COL3_ROWS23] <= ONE_HI;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < tpp_pkg::CFG_IDX_W'(tpp_pkg::N_REGS))) begin
      regs[cfg_index[tpp_pkg::REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Matrix entry M[r][c] sits in register 2c + r/2, half r%2.
  logic signed [CW-1:0] mat [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = (r % 2 == 1) ? regs[c*2 + r/2][2*CW-1:CW] : regs[c*2 + r/2][CW-1:0];
      end
    end
  end

  // Stage control: a stage loads when it is empty or its successor moves on.
  logic [S-1:0] vld;
  logic [S-1:0] adv;
  logic [S-1:0] vld_next;

  always_comb begin
    adv[S-1] = !vld[S-1] || !out_stall;
    for (int s = S - 2; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
    vld_next[0] = adv[0] ? in_valid : vld[0];
    for (int s = 1; s < S; s++) begin
      if (adv[s]) vld_next[s] = vld[s-1];
      else        vld_next[s] = vld[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= vld_next;
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[S-1];

  // Stage 0: products.
  logic signed [2*CW-1:0] prod [3][4];
  logic signed [SW-1:0]   trans [4];
  logic signed [CW-1:0]   pt [3];

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) prod[r][c] <= pt[r] * mat[r][c];
        trans[c] <= SW'(mat[3][c]) <<< FRAC_BITS;
      end
    end
  end

  // Stage 1: column sums.
  logic signed [SW-1:0] csum [4];
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int c = 0; c < 4; c++) begin
        csum[c] <= trans[c] + SW'(prod[0][c]) + SW'(prod[1][c]) + SW'(prod[2][c]);
      end
    end
  end

  // Stage 2: magnitudes and signs.
  logic [MW-1:0] nmag [3];
  logic          lneg [3];
  logic [MW-1:0] wmag;
  logic          wzero;
  logic          wneg_c;

  assign wneg_c = csum[3][SW-1];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      wmag  <= MW'(wneg_c ? -csum[3] : csum[3]);
      wzero <= (csum[3] == '0);
      for (int c = 0; c < 3; c++) begin
        nmag[c] <= MW'(csum[c][SW-1] ? -csum[c] : csum[c]);
        lneg[c] <= csum[c][SW-1] ^ wneg_c;
      end
    end
  end

  // The zero-w flag follows the divider stages.
  logic dbz_s [DIV0:OUTS-1];
  always_ff @(posedge clk) begin
    if (adv[DIV0]) dbz_s[DIV0] <= wzero;
    for (int s = DIV0 + 1; s < OUTS; s++) begin
      if (adv[s]) dbz_s[s] <= dbz_s[s-1];
    end
  end

  logic [QW-1:0] quo [3];
  logic          ovf [3];
  logic          qneg [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    tpp_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (adv[OUTS-1:DIV0]),
      .num_mag (nmag[c]),
      .den     (wmag),
      .neg_in  (lneg[c]),
      .quo     (quo[c]),
      .ovf     (ovf[c]),
      .neg     (qneg[c])
    );
  end

  // Output stage: sign, saturation and the zero-w override.
  logic [CW-1:0] res [3];
  logic          sat [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!qneg[c]) begin
        sat[c] = ovf[c] || (quo[c] > QW'(tpp_pkg::COORD_MAX));
        res[c] = sat[c] ? tpp_pkg::COORD_MAX : quo[c][CW-1:0];
      end else begin
        sat[c] = ovf[c] || (quo[c] > QW'(tpp_pkg::COORD_MIN));
        res[c] = sat[c] ? tpp_pkg::COORD_MIN : (CW'(0) - quo[c][CW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUTS]) begin
      if (dbz_s[OUTS-1]) begin
        out_x       <= '0;
        out_y       <= '0;
        out_z       <= '0;
        div_by_zero <= 1'b1;
        saturated   <= 1'b0;
      end else begin
        out_x       <= res[0];
        out_y       <= res[1];
        out_z       <= res[2];
        div_by_zero <= 1'b0;
        saturated   <= sat[0] || sat[1] || sat[2];
      end
    end
  end

  a_stall_full : assert property (@(posedge clk) disable iff (rst) in_stall |-> (&vld))
    else $error("input stalled while a pipeline stage was empty");

  a_dbz_zero : assert property (@(posedge clk) disable iff (rst)
      (out_valid && div_by_zero) |-> (out_x == '0 && out_y == '0 && out_z == '0 && !saturated))
    else $error("zero w word carried non-zero coordinates or a saturation flag");

  a_sat_rail : assert property (@(posedge clk) disable iff (rst)
      (out_valid && saturated) |->
        (out_x == tpp_pkg::COORD_MAX || out_x == tpp_pkg::COORD_MIN ||
         out_y == tpp_pkg::COORD_MAX || out_y == tpp_pkg::COORD_MIN ||
         out_z == tpp_pkg::COORD_MAX || out_z == tpp_pkg::COORD_MIN))
    else $error("saturation flagged with no coordinate on a rail");

endmodule

/* tb/tb_transform_point_perspective_unit.sv */
// Testbench for transform_point_perspective_unit: a 4x4 homogeneous transform with
// perspective divide, checked word by word against an in-bench predictor.
// Depends on tpp_pkg and the RTL of the block only.
module tb_transform_point_perspective_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = tpp_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam int IW = tpp_pkg::CFG_IDX_W;
  localparam logic [IW-1:0] IDX_UNMAPPED = IW'(tpp_pkg::N_REGS);
  localparam logic [31:0] ONE_FX = 32'd1 << FRAC;

  typedef struct {
    logic signed [tpp_pkg::COORD_W-1:0] x;
    logic signed [tpp_pkg::COORD_W-1:0] y;
    logic signed [tpp_pkg::COORD_W-1:0] z;
    logic dz;
    logic sat;
  } point_result_t;

  class tpp_scoreboard;
    logic [tpp_pkg::CFG_W-1:0] matrix_regs [tpp_pkg::N_REGS];
    point_result_t projected_q[$];
    int errors;

    function new();
      errors = 0;
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
      matrix_regs[tpp_pkg::REG_COL0_ROWS01] = {32'h0, ONE_FX};
      matrix_regs[tpp_pkg::REG_COL1_ROWS01] = {ONE_FX, 32'h0};
      matrix_regs[tpp_pkg::REG_COL2_ROWS23] = {32'h0, ONE_FX};
      matrix_regs[tpp_pkg::REG_COL3_ROWS23] = {ONE_FX, 32'h0};
    endfunction

    function void write_reg(logic [IW-1:0] idx, logic [tpp_pkg::CFG_W-1:0] d);
      if (idx < tpp_pkg::N_REGS) matrix_regs[idx[tpp_pkg::REG_SEL_W-1:0]] = d;
    endfunction

    function logic signed [tpp_pkg::SUM_W-1:0] column_sum(
        logic signed [tpp_pkg::SUM_W-1:0] p[3], int c);
      logic signed [tpp_pkg::SUM_W-1:0] s;
      logic signed [tpp_pkg::SUM_W-1:0] m;
      logic [tpp_pkg::CFG_W-1:0] r;
      s = '0;
      for (int row = 0; row < 4; row++) begin
        r = matrix_regs[c * 2 + row / 2];
        m = $signed(r[(row % 2) * 32 +: 32]);
        if (row == 3) s = s + (m <<< FRAC);
        else s = s + p[row] * m;
      end
      return s;
    endfunction

    // Works out the projected point for an accepted input word and queues it.
    function void note_point(logic signed [31:0] ix, logic signed [31:0] iy,
                             logic signed [31:0] iz);
      logic signed [tpp_pkg::SUM_W-1:0] p[3];
      logic signed [tpp_pkg::SUM_W-1:0] wsum;
      logic signed [tpp_pkg::SUM_W-1:0] nsum;
      logic [tpp_pkg::SUM_W-1:0] wmag;
      logic [tpp_pkg::SUM_W+FRAC-1:0] num;
      logic [tpp_pkg::SUM_W+FRAC-1:0] q;
      logic [tpp_pkg::COORD_W-1:0] res[3];
      point_result_t e;
      bit neg;
      p[0] = ix;
      p[1] = iy;
      p[2] = iz;
      e.sat = 1'b0;
      e.dz = 1'b0;
      wsum = column_sum(p, 3);
      if (wsum == 0) begin
        e.x = '0; e.y = '0; e.z = '0; e.dz = 1'b1;
      end else begin
        wmag = wsum < 0 ? -wsum : wsum;
        for (int c = 0; c < 3; c++) begin
          nsum = column_sum(p, c);
          num = nsum < 0 ? -nsum : nsum;
          num = num << FRAC;
          q = num / wmag;
          neg = (nsum < 0) != (wsum < 0);
          if (!neg && q > 'h7FFF_FFFF) begin
            res[c] = tpp_pkg::COORD_MAX; e.sat = 1'b1;
          end else if (neg && q > 'h8000_0000) begin
            res[c] = tpp_pkg::COORD_MIN; e.sat = 1'b1;
          end else if (neg) begin
            res[c] = -q[31:0];
          end else begin
            res[c] = q[31:0];
          end
        end
        e.x = res[0]; e.y = res[1]; e.z = res[2];
      end
      projected_q.push_back(e);
    endfunction

    function void check_result(point_result_t got);
      point_result_t e;
      if (projected_q.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      e = projected_q.pop_front();
      if (got.x !== e.x) begin
        $error("out_x expected %h actual %h", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("out_y expected %h actual %h", e.y, got.y); errors++;
      end
      if (got.z !== e.z) begin
        $error("out_z expected %h actual %h", e.z, got.z); errors++;
      end
      if (got.dz !== e.dz) begin
        $error("div_by_zero expected %b actual %b", e.dz, got.dz); errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, got.sat); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [tpp_pkg::COORD_W-1:0] in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tpp_pkg::COORD_W-1:0] out_x, out_y, out_z;
  logic div_by_zero, saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [tpp_pkg::CFG_W-1:0] cfg_data = '0;

  tpp_scoreboard board;
  bit hold_request = 1'b0;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  transform_point_perspective_unit dut (.*);

  always @(posedge clk) begin
    point_result_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got.x = out_x; got.y = out_y; got.z = out_z;
      got.dz = div_by_zero; got.sat = saturated;
      board.check_result(got);
    end
  end

  // Receiver back-pressure: a long hold-off on request, otherwise a shifting pattern.
  initial begin
    int hold;
    int mode;
    hold = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold = 300;
        out_stall = 1'b1;
      end else begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) == 0);
          2: out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  task automatic write_cfg(logic [IW-1:0] idx, logic [tpp_pkg::CFG_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return tpp_pkg::COORD_MAX;
      1: return tpp_pkg::COORD_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? ONE_FX : -ONE_FX;
      4, 5, 6: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word; the caller is at a falling edge. Returns at the accepting edge.
  task automatic offer_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid = 1'b1;
    in_x = x; in_y = y; in_z = z;
    do @(posedge clk); while (in_stall);
    board.note_point(x, y, z);
  endtask

  task automatic send_points(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        @(negedge clk);
        offer_point(pick_coord(), pick_coord(), pick_coord());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (board.projected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] small_entry();
    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
  endfunction

  initial begin
    logic [31:0] corner[5];
    board = new();
    corner = '{tpp_pkg::COORD_MAX, tpp_pkg::COORD_MIN, 32'h0, ONE_FX, 32'hFFFF_FFFF};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity matrix after reset: corner points pass straight through.
    for (int i = 0; i < 20; i++) begin
      @(negedge clk);
      offer_point(corner[i % 5], corner[(i / 5) % 5], corner[(i + 2) % 5]);
    end
    @(negedge clk);
    in_valid = 1'b0;
    send_points(150);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: for (int r = 0; r < tpp_pkg::N_REGS; r++) write_cfg(IW'(r), {$urandom, $urandom});
        1: for (int r = 0; r < tpp_pkg::N_REGS; r++)
             write_cfg(IW'(r), {tpp_pkg::COORD_MIN, tpp_pkg::COORD_MIN});
        2: for (int r = 0; r < tpp_pkg::N_REGS; r++)
             write_cfg(IW'(r), {tpp_pkg::COORD_MAX, tpp_pkg::COORD_MAX});
        3: begin
          // No w column at all, so every point divides by zero.
          write_cfg(IW'(tpp_pkg::REG_COL3_ROWS01), '0);
          write_cfg(IW'(tpp_pkg::REG_COL3_ROWS23), '0);
        end
        4: for (int r = 0; r < tpp_pkg::N_REGS; r++)
             write_cfg(IW'(r), {small_entry(), small_entry()});
        5: begin
          // w taken from x alone: zero x gives a zero w.
          write_cfg(IW'(tpp_pkg::REG_COL3_ROWS01), {32'h0, small_entry()});
          write_cfg(IW'(tpp_pkg::REG_COL3_ROWS23), '0);
        end
        6: begin
          for (int r = 0; r < tpp_pkg::N_REGS; r++)
            write_cfg(IW'(r), {small_entry(), $urandom});
          write_cfg(IW'(tpp_pkg::REG_COL3_ROWS23), {ONE_FX, small_entry()});
        end
        default: for (int r = 0; r < tpp_pkg::N_REGS; r++)
                   write_cfg(IW'(r), {$urandom, small_entry()});
      endcase
      write_cfg(IW'(IDX_UNMAPPED + $urandom_range(0, 2**IW - 1 - tpp_pkg::N_REGS)),
                {$urandom, $urandom});
      if (phase == 2) hold_request = 1'b1;
      send_points(230);
      drain();
    end

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/tpp_pkg.sv
hw/rtl/tpp_div_lane.sv
hw/rtl/transform_point_perspective_unit.sv
tb/tb_transform_point_perspective_unit.sv
